// ===== rtl/eaud_pkg.sv =====
// ----------------------------------------------------------------------------
// eaud_pkg: shared types and constants of the escaped ASCII decoder
// Escape decoder modes, result status codes and the character codes it tests.
// ----------------------------------------------------------------------------
package eaud_pkg;

    // Decoder mode; codes 6 and 9..15 are unused and decode as plain
    typedef enum logic [3:0] {
        MODE_PLAIN  = 4'd0,
        MODE_BSLASH = 4'd1,
        MODE_HEX0   = 4'd2,
        MODE_HEX1   = 4'd3,
        MODE_HEX2   = 4'd4,
        MODE_HEX3   = 4'd5,
        MODE_OCT1   = 4'd7,
        MODE_OCT2   = 4'd8
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INVALID   = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } t_status;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_UPPER_U   = 8'h55;
    localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
    localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
    localparam logic [7:0] ASCII_LIMIT    = 8'h80;
    localparam logic [3:0] HEX_LETTER_OFS = 4'd9;   // 'A' (low nibble 1) -> 10

endpackage

// ===== rtl/escaped_ascii_to_utf16_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// escaped_ascii_to_utf16_decoder_unit: backslash escape decoder to UTF-16
// Takes one byte per transaction and produces at most one code unit result.
// ----------------------------------------------------------------------------
// The unit takes one byte of an escaped 7-bit string per input transaction,
// with i_end_of_string marking the final byte, and returns UTF-16 code units.
// Plain bytes below 0x80 pass straight through; a backslash followed by u or
// U opens four hex digits (either case); a backslash followed by a decimal
// digit opens a three digit escape combined as (value << 3) | digit, where
// 8 and 9 are ORed in as they stand; a double backslash yields a backslash.
// Any other byte after a backslash, a bad digit inside an escape, or a byte
// of 0x80 or above flags an error, after which the rest of the string is
// swallowed. The final byte always yields exactly one result with o_last
// set: status 1 if an error was seen, status 2 if an escape was left open,
// otherwise status 0 with the completed unit. Bytes that complete nothing
// give no result. Throughput is one byte per clock while the result register
// can take it: the decode is a single combinational step from the input port into
// the result register, and a new byte is taken whenever that register is
// empty or is being emptied in the same cycle. All decoder state clears
// after each final byte.
module escaped_ascii_to_utf16_decoder_unit
    import eaud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_string,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_has_unit,
    output logic [15:0] o_code_unit,
    output logic [1:0]  o_status,
    output logic        o_last
);

    // decoder state
    t_mode       r_mode;
    t_mode       n_mode;
    logic [15:0] r_acc;
    logic [15:0] n_acc;
    logic        r_err;
    logic        n_err;

    // result register
    logic        r_out_valid;
    logic        r_has_unit;
    logic [15:0] r_code_unit;
    t_status     r_status;
    logic        r_last;
    logic        n_has_unit;
    logic [15:0] n_code_unit;
    t_status     n_status;

    logic        in_take;
    logic        emit;
    logic        bad;
    logic        is_dec;
    logic        is_hex_letter;
    logic        is_hex;
    logic [3:0]  hex_val;

    // result register frees up in the same cycle it is read out
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;

    // character classes
    assign is_dec = (i_in_byte >= CHAR_DIGIT_0) && (i_in_byte <= CHAR_DIGIT_9);
    // 'A'..'F' or 'a'..'f': high bits 010/011, then 00 and 1..6
    assign is_hex_letter = (i_in_byte[7:6] == 2'b01) && (i_in_byte[4:3] == 2'b00)
                        && (i_in_byte[2:0] != 3'd0) && (i_in_byte[2:0] != 3'd7);
    assign is_hex  = is_dec || is_hex_letter;
    assign hex_val = is_dec ? i_in_byte[3:0] : (i_in_byte[3:0] + HEX_LETTER_OFS);

    // next state and result
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_err  = r_err;
        emit   = 1'b0;
        bad    = 1'b0;

        if (!r_err) begin
            case (r_mode)
                MODE_BSLASH: begin
                    if (i_in_byte == CHAR_UPPER_U || i_in_byte == CHAR_LOWER_U) begin
                        n_mode = MODE_HEX0;
                        n_acc  = '0;
                    end else if (is_dec) begin
                        n_mode = MODE_OCT1;
                        n_acc  = {12'd0, i_in_byte[3:0]};
                    end else if (i_in_byte == CHAR_BACKSLASH) begin
                        n_mode = MODE_PLAIN;
                        n_acc  = {8'd0, CHAR_BACKSLASH};
                        emit   = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                    if (is_hex) begin
                        n_acc = {r_acc[11:0], hex_val};
                        case (r_mode)
                            MODE_HEX0: n_mode = MODE_HEX1;
                            MODE_HEX1: n_mode = MODE_HEX2;
                            MODE_HEX2: n_mode = MODE_HEX3;
                            default: begin
                                n_mode = MODE_PLAIN;
                                emit   = 1'b1;
                            end
                        endcase
                    end else begin
                        bad = 1'b1;
                    end
                end
                MODE_OCT1, MODE_OCT2: begin
                    if (is_dec) begin
                        // digit ORed in, so 8 and 9 overlap the shifted bits
                        n_acc = {r_acc[12:0], 3'd0} | {12'd0, i_in_byte[3:0]};
                        if (r_mode == MODE_OCT1) begin
                            n_mode = MODE_OCT2;
                        end else begin
                            n_mode = MODE_PLAIN;
                            emit   = 1'b1;
                        end
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: begin
                    // plain mode, and any unused code
                    n_mode = MODE_PLAIN;
                    if (i_in_byte == CHAR_BACKSLASH) begin
                        n_mode = MODE_BSLASH;
                    end else if (i_in_byte < ASCII_LIMIT) begin
                        n_acc = {8'd0, i_in_byte};
                        emit  = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
            endcase
        end

        if (bad) begin
            n_err  = 1'b1;
            n_mode = MODE_PLAIN;
            emit   = 1'b0;
        end

        // result fields
        if (n_err) begin
            n_status = STATUS_INVALID;
        end else if (!emit) begin
            n_status = STATUS_TRUNCATED;
        end else begin
            n_status = STATUS_OK;
        end
        if (!i_end_of_string) begin
            n_status = STATUS_OK;
        end
        n_has_unit  = (n_status == STATUS_OK);
        n_code_unit = (n_status == STATUS_OK) ? n_acc : 16'd0;

        // string closed: back to reset state
        if (i_end_of_string) begin
            n_mode = MODE_PLAIN;
            n_acc  = '0;
            n_err  = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_acc  <= '0;
            r_err  <= 1'b0;
        end else if (in_take) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_err  <= n_err;
        end
    end

    // result valid: a unit completed, or the string closed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= emit || i_end_of_string;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_has_unit  <= n_has_unit;
            r_code_unit <= n_code_unit;
            r_status    <= n_status;
            r_last      <= i_end_of_string;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_has_unit  = r_has_unit;
    assign o_code_unit = r_code_unit;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

// ===== rtl/eaud_checker.sv =====
// ----------------------------------------------------------------------------
// eaud_checker: port level checks of the escaped ASCII decoder
// Watches the top level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module eaud_checker
    import eaud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic        o_has_unit,
    input  logic [15:0] o_code_unit,
    input  logic [1:0]  o_status,
    input  logic        o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_code_unit)
            && $stable(o_status) && $stable(o_last))
        else $error("result changed while stalled");

    // input side never blocked by an empty result register
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with no pending result");

    // mid-string results always carry a unit
    a_mid_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_has_unit && (o_status == STATUS_OK))
        else $error("mid-string result without unit");

    // unit flag and status agree, empty results carry zero
    a_status_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_has_unit == (o_status == STATUS_OK))
            && (o_has_unit || (o_code_unit == 16'd0)))
        else $error("status and unit flag disagree");

    // error results only close a string (see a_mid_unit); every result uses a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STATUS_OK) || (o_status == STATUS_INVALID)
            || (o_status == STATUS_TRUNCATED))
        else $error("undefined status code");

endmodule

bind escaped_ascii_to_utf16_decoder_unit eaud_checker u_eaud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_has_unit  (o_has_unit),
    .o_code_unit (o_code_unit),
    .o_status    (o_status),
    .o_last      (o_last)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for escaped_ascii_to_utf16_decoder_unit
// Drives escaped byte strings through the valid/ready input channel, predicts
// each result transaction with a behavioural decoder model and checks every
// result field in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import eaud_pkg::*;

    // Character codes used by the bench's own decoder model and byte generators
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CASE_GAP     = 8'h20;   // 'a' - 'A'
    localparam logic [3:0] HEX_TEN      = 4'd10;

    // Watchdog limit; leave plenty of headroom over the slowest run
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TAIL_CYCLES = 5;

    typedef struct packed {
        logic        has_unit;
        logic [15:0] code_unit;
        logic [1:0]  status;
        logic        last;
    } t_result;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte       = 8'h00;
    logic        i_end_of_string = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic        o_has_unit;
    logic [15:0] o_code_unit;
    logic [1:0]  o_status;
    logic        o_last;

    // Hold-off chance in percent: the sender's before each byte, the receiver's at each redraw
    int unsigned tx_idle_pct = 25;
    int unsigned rx_idle_pct = 85;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Result transactions still owed by the block, oldest first
    t_result pending_units[$];

    // Decoder model state
    t_mode       dec_mode  = MODE_PLAIN;
    logic [15:0] dec_value = 16'h0000;
    logic        dec_error = 1'b0;

    escaped_ascii_to_utf16_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_has_unit      (o_has_unit),
        .o_code_unit     (o_code_unit),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Decoder model: advances the state by one byte. Returns 1 when the byte
    // produces a result transaction, which is then returned in res.
    // ------------------------------------------------------------------------
    function automatic bit decode_byte(input logic [7:0] b, input logic fin,
                                       output t_result res);
        logic       emit;
        logic       bad;
        logic       is_dec;
        logic [7:0] folded;
        logic [3:0] digit;
        t_status    st;
        emit   = 1'b0;
        bad    = 1'b0;
        is_dec = (b >= CHAR_DIGIT_0) && (b <= CHAR_DIGIT_9);
        digit  = 4'd0;
        res    = '0;

        // Once an error is flagged the rest of the string is swallowed
        if (!dec_error) begin
            case (dec_mode)
                MODE_BSLASH: begin
                    if (b == CHAR_UPPER_U || b == CHAR_LOWER_U) begin
                        dec_mode  = MODE_HEX0;
                        dec_value = 16'h0000;
                    end else if (is_dec) begin
                        dec_mode  = MODE_OCT1;
                        dec_value = {12'h000, b[3:0]};
                    end else if (b == CHAR_BACKSLASH) begin
                        dec_mode  = MODE_PLAIN;
                        dec_value = {8'h00, CHAR_BACKSLASH};
                        emit      = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                    folded = (b >= CHAR_LOWER_A) ? b - CASE_GAP : b;
                    if (is_dec) begin
                        digit = b[3:0];
                    end else if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_F) begin
                        digit = folded[3:0] - CHAR_UPPER_A[3:0] + HEX_TEN;
                    end else begin
                        bad = 1'b1;
                    end
                    if (!bad) begin
                        // four nibbles fill the unit; older bits fall off the top
                        dec_value = {dec_value[11:0], digit};
                        if (dec_mode == MODE_HEX3) begin
                            dec_mode = MODE_PLAIN;
                            emit     = 1'b1;
                        end else begin
                            dec_mode = t_mode'(dec_mode + 4'd1);
                        end
                    end
                end
                MODE_OCT1, MODE_OCT2: begin
                    if (!is_dec) begin
                        bad = 1'b1;
                    end else begin
                        // 8 and 9 are ORed in whole, spilling into the next bit
                        dec_value = {dec_value[12:0], 3'b000} | {12'h000, b[3:0]};
                        if (dec_mode == MODE_OCT2) begin
                            dec_mode = MODE_PLAIN;
                            emit     = 1'b1;
                        end else begin
                            dec_mode = MODE_OCT2;
                        end
                    end
                end
                default: begin
                    if (b == CHAR_BACKSLASH) begin
                        dec_mode = MODE_BSLASH;
                    end else if (b < ASCII_LIMIT) begin
                        dec_value = {8'h00, b};
                        emit      = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
            endcase
            if (bad) begin
                dec_error = 1'b1;
                dec_mode  = MODE_PLAIN;
                emit      = 1'b0;
            end
        end

        if (!fin) begin
            res = '{has_unit: 1'b1, code_unit: dec_value, status: STATUS_OK, last: 1'b0};
            return emit;
        end

        // Final byte always closes the string with exactly one result
        if (dec_error)
            st = STATUS_INVALID;
        else if (!emit)
            st = STATUS_TRUNCATED;
        else
            st = STATUS_OK;
        res.has_unit  = (st == STATUS_OK);
        res.code_unit = (st == STATUS_OK) ? dec_value : 16'h0000;
        res.status    = st;
        res.last      = 1'b1;
        dec_mode  = MODE_PLAIN;
        dec_value = 16'h0000;
        dec_error = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char();
        logic [3:0] d;
        d = 4'($urandom_range(15));
        if (d < HEX_TEN)
            return CHAR_DIGIT_0 + d;
        return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + (d - HEX_TEN);
    endfunction

    // ------------------------------------------------------------------------
    // Send one byte as an input transaction. An optional hold-off drops valid
    // first; otherwise valid stays high straight on from the previous byte.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fin);
        t_result     res;
        int unsigned gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_end_of_string <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        if (decode_byte(b, fin, res))
            pending_units.push_back(res);
    endtask

    // Receiver back-pressure, redrawn every cycle
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // ------------------------------------------------------------------------
    // Result checker: every accepted result transaction is matched against
    // the oldest outstanding prediction, field by field.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_units.size() == 0) begin
                error_count++;
                $error("result with nothing expected: unit %h status %0d last %0d",
                       o_code_unit, o_status, o_last);
            end else begin
                want = pending_units.pop_front();
                if (o_has_unit !== want.has_unit) begin
                    error_count++;
                    $error("has_unit: expected %0d, got %0d", want.has_unit, o_has_unit);
                end
                if (o_code_unit !== want.code_unit) begin
                    error_count++;
                    $error("code_unit: expected %h, got %h", want.code_unit, o_code_unit);
                end
                if (o_status !== want.status) begin
                    error_count++;
                    $error("status: expected %0d, got %0d", want.status, o_status);
                end
                if (o_last !== want.last) begin
                    error_count++;
                    $error("last: expected %0d, got %0d", want.last, o_last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Plain bytes at both ends of the 7-bit range, last one closing a string
    task automatic test_plain_bytes();
        send_byte("A", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // Hex escapes in both cases, the full 16-bit value, the three digit
    // escape with 9s, and the double backslash
    task automatic test_escape_forms();
        send_byte(CHAR_BACKSLASH, 1'b0);
        send_byte(CHAR_LOWER_U, 1'b0);
        send_byte("0", 1'b0);
        send_byte("9", 1'b0);
        send_byte("a", 1'b0);
        send_byte("F", 1'b0);
        send_byte(CHAR_BACKSLASH, 1'b0);
        send_byte(CHAR_UPPER_U, 1'b0);
        send_byte("f", 1'b0);
        send_byte("F", 1'b0);
        send_byte("f", 1'b0);
        send_byte("F", 1'b1);
        send_byte(CHAR_BACKSLASH, 1'b0);
        send_byte("9", 1'b0);
        send_byte("9", 1'b0);
        send_byte("9", 1'b1);
        send_byte(CHAR_BACKSLASH, 1'b0);
        send_byte(CHAR_BACKSLASH, 1'b1);
    endtask

    // Byte above the 7-bit range, swallowed tail, open escape at string end,
    // and an error on the final byte itself
    task automatic test_error_cases();
        send_byte(ASCII_LIMIT, 1'b0);
        send_byte("q", 1'b1);
        send_byte(CHAR_BACKSLASH, 1'b1);
        send_byte(CHAR_BACKSLASH, 1'b0);
        send_byte("x", 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Random strings: mostly plain bytes and well-formed escapes with random
    // content, plus stray bytes, bad escapes and strings cut off in an escape.
    // ------------------------------------------------------------------------
    task automatic test_random_strings(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int unsigned n_bytes);
        logic [7:0]  text[$];
        logic [7:0]  b;
        int unsigned sent;
        int unsigned n_tok;
        int unsigned kind;
        int unsigned k;
        int unsigned j;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent        = 0;
        while (sent < n_bytes) begin
            text.delete();
            n_tok = $urandom_range(1, 8);
            for (k = 0; k < n_tok; k++) begin
                kind = $urandom_range(99);
                if (kind < 40) begin
                    b = 8'($urandom_range(8'h7F));
                    text.push_back(b == CHAR_BACKSLASH ? CHAR_UPPER_A : b);
                end else if (kind < 60) begin
                    text.push_back(CHAR_BACKSLASH);
                    text.push_back($urandom_range(1) ? CHAR_UPPER_U : CHAR_LOWER_U);
                    for (j = 0; j < 4; j++)
                        text.push_back(hex_char());
                end else if (kind < 75) begin
                    text.push_back(CHAR_BACKSLASH);
                    for (j = 0; j < 3; j++)
                        text.push_back(CHAR_DIGIT_0 + 8'($urandom_range(9)));
                end else if (kind < 85) begin
                    text.push_back(CHAR_BACKSLASH);
                    text.push_back(CHAR_BACKSLASH);
                end else if (kind < 93) begin
                    text.push_back(8'($urandom_range(255)));
                end else begin
                    // escape with an arbitrary, usually illegal, follower
                    text.push_back(CHAR_BACKSLASH);
                    text.push_back(8'($urandom_range(255)));
                end
            end
            // Now and then leave an escape open at the end of the string
            if ($urandom_range(9) == 0) begin
                text.push_back(CHAR_BACKSLASH);
                if ($urandom_range(1)) begin
                    text.push_back(CHAR_LOWER_U);
                    for (j = $urandom_range(3); j > 0; j--)
                        text.push_back(hex_char());
                end else if ($urandom_range(1)) begin
                    for (j = $urandom_range(1, 2); j > 0; j--)
                        text.push_back(CHAR_DIGIT_0 + 8'($urandom_range(9)));
                end
            end
            for (j = 0; j < text.size(); j++)
                send_byte(text[j], j == text.size() - 1);
            sent += text.size();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_bytes();
        test_escape_forms();
        test_error_cases();
        test_random_strings(25, 85, 250);
        test_random_strings(85, 25, 250);
        test_random_strings(0, 0, 250);

        // Drain: stop sending and wait for every owed result
        i_in_valid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== escaped_ascii_to_utf16_decoder_unit.f =====
rtl/eaud_pkg.sv
rtl/escaped_ascii_to_utf16_decoder_unit.sv
rtl/eaud_checker.sv
bench/testbench.sv
